FILE: rtl/skvt_pkg.sv
// Shared types and constants for the sorted key/value table.
// Used by skvt_cell, skvt_group and sorted_key_value_table; depends on nothing.
`default_nettype none

package skvt_pkg;

  // Field widths and default sizing
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned DEPTH_DEF = 16;
  // Cells folded by one registered reduction group
  localparam int unsigned GRP_W     = 16;

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic ins;  // open a hole at the insert point, shift upper part up
    logic rem;  // close the hit slot, shift upper part down
  } ctl_t;

endpackage

`default_nettype wire

FILE: rtl/skvt_cell.sv
// One slot of the sorted chain: holds a key/value pair and its compare flags.
// Depends on skvt_pkg for widths and the shift command struct.
`default_nettype none

module skvt_cell (
  input  wire logic                              clk_i,
  input  wire logic                              cmp_en_i,
  input  wire logic                              occ_i,
  input  wire logic signed [skvt_pkg::KEY_W-1:0] req_key_i,
  input  wire logic signed [skvt_pkg::VAL_W-1:0] req_value_i,
  input  wire skvt_pkg::ctl_t                    ctl_i,
  input  wire logic                              left_lt_i,
  input  wire logic signed [skvt_pkg::KEY_W-1:0] left_key_i,
  input  wire logic signed [skvt_pkg::VAL_W-1:0] left_value_i,
  input  wire logic signed [skvt_pkg::KEY_W-1:0] right_key_i,
  input  wire logic signed [skvt_pkg::VAL_W-1:0] right_value_i,
  output logic signed [skvt_pkg::KEY_W-1:0]      key_o,
  output logic signed [skvt_pkg::VAL_W-1:0]      value_o,
  output logic                                   lt_o,
  output logic                                   eq_o
);

  logic signed [skvt_pkg::KEY_W-1:0] key_q, key_d;
  logic signed [skvt_pkg::VAL_W-1:0] value_q, value_d;
  logic                              lt_q, eq_q;

  // Pick the next slot contents from the shift command
  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    if (ctl_i.ins && !lt_q) begin
      if (left_lt_i) begin
        key_d   = req_key_i;
        value_d = req_value_i;
      end else begin
        key_d   = left_key_i;
        value_d = left_value_i;
      end
    end else if (ctl_i.rem && !lt_q) begin
      key_d   = right_key_i;
      value_d = right_value_i;
    end
  end

  // Slot contents need no reset: only occupied slots are ever looked at
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  // Compare against the pending request key
  always_ff @(posedge clk_i) begin
    if (cmp_en_i) begin
      lt_q <= occ_i && (key_q < req_key_i);
      eq_q <= occ_i && (key_q == req_key_i);
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

`default_nettype wire

FILE: rtl/skvt_group.sv
// Registered hit/value reduction over one group of cells.
// Depends on skvt_pkg for the value width and default group size.
`default_nettype none

module skvt_group #(
  parameter int unsigned LANES = skvt_pkg::GRP_W
) (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic [LANES-1:0]                  eq_i,
  input  wire logic [LANES-1:0][skvt_pkg::VAL_W-1:0] value_i,
  output logic                                   hit_o,
  output logic [skvt_pkg::VAL_W-1:0]             value_o
);

  logic                       hit_d, hit_q;
  logic [skvt_pkg::VAL_W-1:0] value_d, value_q;

  // Fold the one-hot match into a flag and the matching value
  always_comb begin
    hit_d   = 1'b0;
    value_d = '0;
    for (int unsigned i = 0; i < LANES; i++) begin
      hit_d   = hit_d | eq_i[i];
      value_d = value_d | (value_i[i] & {skvt_pkg::VAL_W{eq_i[i]}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q   <= hit_d;
      value_q <= value_d;
    end
  end

  assign hit_o   = hit_q;
  assign value_o = value_q;

endmodule

`default_nettype wire

FILE: rtl/sorted_key_value_table.sv
// Top level of the sorted key/value table: cell chain, reduction groups, control.
// Depends on skvt_pkg, skvt_cell and skvt_group.
//
// Usage:
//  - Request channel (req_valid_i / req_stall_o) carries one beat per request:
//    req_type_i selects insert (key_i with value_i) or remove (by key_i).
//  - Response channel (rsp_valid_o / rsp_stall_i) returns exactly one beat per
//    request: status_o and removed_value_o, in request order.
//  - A beat moves at a rising edge with valid high and stall low.
//  - Each request passes through these steps from acceptance to its response
//    beat: it is latched, every cell compares its key in parallel, the group
//    reduction of the match is registered, and the chain shifts while the
//    response register loads. The block takes a new request in the cycle
//    after that shift and not before, so requests do not overlap; the
//    sustained rate is set by the compare/reduce/shift sequence through the chain.
//  - The response register frees the chain: a request can be accepted while
//    the previous response still waits. If the receiver stalls, the next
//    request finishes its compare and then holds in the shift step.
//  - Reset empties the table (entry count to zero) and drops any pending
//    beat; no clearing pass is needed, slot contents are ignored when empty.
`default_nettype none

module sorted_key_value_table #(
  parameter int unsigned DEPTH = skvt_pkg::DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              req_valid_i,
  output logic                                   req_stall_o,
  input  wire logic                              req_type_i,
  input  wire logic signed [skvt_pkg::KEY_W-1:0] key_i,
  input  wire logic signed [skvt_pkg::VAL_W-1:0] value_i,
  output logic                                   rsp_valid_o,
  input  wire logic                              rsp_stall_i,
  output logic [1:0]                             status_o,
  output logic signed [skvt_pkg::VAL_W-1:0]      removed_value_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned NG    = (DEPTH + skvt_pkg::GRP_W - 1) / skvt_pkg::GRP_W;
  localparam int unsigned NPAD  = NG * skvt_pkg::GRP_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_RED   = 4'b0100,
    S_APPLY = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]                   count_q, count_d;
  logic                               type_q;
  logic signed [skvt_pkg::KEY_W-1:0]  rkey_q;
  logic signed [skvt_pkg::VAL_W-1:0]  rval_q;

  logic                               rsp_valid_q;
  skvt_pkg::status_e                  status_q, status_d;
  logic [skvt_pkg::VAL_W-1:0]         removed_q, removed_d;

  logic                               req_acc;
  logic                               fire;
  logic                               hit;
  logic [skvt_pkg::VAL_W-1:0]         hit_value;
  skvt_pkg::ctl_t                     ctl;

  logic signed [skvt_pkg::KEY_W-1:0]  cell_key [DEPTH];
  logic signed [skvt_pkg::VAL_W-1:0]  cell_val [DEPTH];
  logic [DEPTH-1:0]                   cell_lt;
  logic [DEPTH-1:0]                   cell_eq;

  logic [NPAD-1:0]                              eq_pad;
  logic [NPAD-1:0][skvt_pkg::VAL_W-1:0]         val_pad;
  logic [NG-1:0]                                grp_hit;
  logic [NG-1:0][skvt_pkg::VAL_W-1:0]           grp_val;

  assign req_stall_o = (state_q != S_IDLE);
  assign req_acc     = req_valid_i && !req_stall_o;
  assign fire        = (state_q == S_APPLY) && (!rsp_valid_q || !rsp_stall_i);

  // Advance through latch, compare, reduce and shift
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (req_acc) state_d = S_CMP;
      S_CMP:   state_d = S_RED;
      S_RED:   state_d = S_APPLY;
      S_APPLY: if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the accepted request beat
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      type_q <= req_type_i;
      rkey_q <= key_i;
      rval_q <= value_i;
    end
  end

  // Combine the group results
  always_comb begin
    hit       = 1'b0;
    hit_value = '0;
    for (int unsigned g = 0; g < NG; g++) begin
      hit       = hit | grp_hit[g];
      hit_value = hit_value | grp_val[g];
    end
  end

  // Decide the outcome and the chain shift
  always_comb begin
    ctl       = '0;
    count_d   = count_q;
    status_d  = skvt_pkg::ST_DONE;
    removed_d = '0;
    if (type_q == skvt_pkg::REQ_INSERT) begin
      if (hit) begin
        status_d = skvt_pkg::ST_DUP;
      end else if (count_q == CNT_W'(DEPTH)) begin
        status_d = skvt_pkg::ST_FULL;
      end else begin
        ctl.ins = fire;
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (!hit) begin
        status_d = skvt_pkg::ST_MISSING;
      end else begin
        ctl.rem   = fire;
        removed_d = hit_value;
        count_d   = count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire) begin
      count_q <= count_d;
    end
  end

  // Response register: load on finish, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (fire) begin
      rsp_valid_q <= 1'b1;
    end else if (!rsp_stall_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q  <= status_d;
      removed_q <= removed_d;
    end
  end

  assign rsp_valid_o     = rsp_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                              left_lt;
    logic signed [skvt_pkg::KEY_W-1:0] left_key, right_key;
    logic signed [skvt_pkg::VAL_W-1:0] left_val, right_val;

    if (i == 0) begin : g_head
      assign left_lt  = 1'b1;
      assign left_key = '0;
      assign left_val = '0;
    end else begin : g_body
      assign left_lt  = cell_lt[i-1];
      assign left_key = cell_key[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_key = cell_key[i];
      assign right_val = cell_val[i];
    end else begin : g_mid
      assign right_key = cell_key[i+1];
      assign right_val = cell_val[i+1];
    end

    skvt_cell u_cell (
      .clk_i         (clk_i),
      .cmp_en_i      (state_q == S_CMP),
      .occ_i         (CNT_W'(i) < count_q),
      .req_key_i     (rkey_q),
      .req_value_i   (rval_q),
      .ctl_i         (ctl),
      .left_lt_i     (left_lt),
      .left_key_i    (left_key),
      .left_value_i  (left_val),
      .right_key_i   (right_key),
      .right_value_i (right_val),
      .key_o         (cell_key[i]),
      .value_o       (cell_val[i]),
      .lt_o          (cell_lt[i]),
      .eq_o          (cell_eq[i])
    );
  end

  // Pad the match lines up to whole groups
  for (genvar i = 0; i < NPAD; i++) begin : g_pad
    if (i < DEPTH) begin : g_real
      assign eq_pad[i]  = cell_eq[i];
      assign val_pad[i] = cell_val[i];
    end else begin : g_zero
      assign eq_pad[i]  = 1'b0;
      assign val_pad[i] = '0;
    end
  end

  // Registered reduction groups
  for (genvar g = 0; g < NG; g++) begin : g_grp
    skvt_group #(
      .LANES (skvt_pkg::GRP_W)
    ) u_group (
      .clk_i   (clk_i),
      .en_i    (state_q == S_RED),
      .eq_i    (eq_pad[g*skvt_pkg::GRP_W +: skvt_pkg::GRP_W]),
      .value_i (val_pad[g*skvt_pkg::GRP_W +: skvt_pkg::GRP_W]),
      .hit_o   (grp_hit[g]),
      .value_o (grp_val[g])
    );
  end

  // Entry count stays within the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds table depth");

  // An accepted request starts its compare in the next cycle
  a_accept_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (state_q == S_CMP))
    else $error("accepted request did not enter compare");

  // A successful insert grows the table by one
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && type_q == skvt_pkg::REQ_INSERT && status_d == skvt_pkg::ST_DONE)
      |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow entry count");

  // Only a successful remove reports a nonzero value
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && status_o != skvt_pkg::ST_DONE) |-> (removed_value_o == '0))
    else $error("nonzero value on failed request");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for sorted_key_value_table: directed and random
// insert/remove traffic against a behavioral table kept in the testbench.
// Depends on skvt_pkg and the sorted_key_value_table RTL.
`timescale 1ns / 100ps

module tb_top;
  import skvt_pkg::*;

  localparam int unsigned TBL_DEPTH = DEPTH_DEF;
  localparam int unsigned POOL_SIZE = 24;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct {
    status_e                  status;
    logic signed [VAL_W-1:0]  removed;
  } table_rsp_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      req_valid_i = 1'b0;
  logic                      req_type_i = REQ_INSERT;
  logic signed [KEY_W-1:0]   key_i = '0;
  logic signed [VAL_W-1:0]   value_i = '0;
  logic                      rsp_stall_i = 1'b0;
  logic                      req_stall_o;
  logic                      rsp_valid_o;
  logic [1:0]                status_o;
  logic signed [VAL_W-1:0]   removed_value_o;

  // Behavioral copy of the table contents
  logic signed [KEY_W-1:0]   tbl_keys [TBL_DEPTH];
  logic signed [VAL_W-1:0]   tbl_vals [TBL_DEPTH];
  int unsigned               tbl_count = 0;
  logic signed [KEY_W-1:0]   key_pool [POOL_SIZE];

  table_rsp_t                pending_rsps [$];
  int unsigned               mismatch_count = 0;
  int unsigned               req_count = 0;
  int unsigned               ins_tally [4] = '{default: 0};
  int unsigned               rem_tally [4] = '{default: 0};
  bit                        sender_idle = 1'b1;
  bit                        receiver_idle = 1'b1;

  sorted_key_value_table #(.DEPTH(TBL_DEPTH)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_valid_i),
    .req_stall_o     (req_stall_o),
    .req_type_i      (req_type_i),
    .key_i           (key_i),
    .value_i         (value_i),
    .rsp_valid_o     (rsp_valid_o),
    .rsp_stall_i     (rsp_stall_i),
    .status_o        (status_o),
    .removed_value_o (removed_value_o)
  );

  // 8 ns clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Apply one request to the sorted table and return the response it yields
  function automatic void apply_request(input logic op, input logic signed [KEY_W-1:0] k,
                                        input logic signed [VAL_W-1:0] v,
                                        output table_rsp_t want);
    int unsigned slot;
    bit          hit;
    slot = 0;
    while (slot < tbl_count && tbl_keys[slot] < k) slot++;
    hit = (slot < tbl_count) && (tbl_keys[slot] == k);
    want.removed = '0;
    if (op == REQ_INSERT) begin
      if (hit) begin
        want.status = ST_DUP;
      end else if (tbl_count >= TBL_DEPTH) begin
        want.status = ST_FULL;
      end else begin
        for (int unsigned i = tbl_count; i > slot; i--) begin
          tbl_keys[i] = tbl_keys[i-1];
          tbl_vals[i] = tbl_vals[i-1];
        end
        tbl_keys[slot] = k;
        tbl_vals[slot] = v;
        tbl_count++;
        want.status = ST_DONE;
      end
      ins_tally[want.status]++;
    end else begin
      if (!hit) begin
        want.status = ST_MISSING;
      end else begin
        want.removed = tbl_vals[slot];
        for (int unsigned i = slot; i + 1 < tbl_count; i++) begin
          tbl_keys[i] = tbl_keys[i+1];
          tbl_vals[i] = tbl_vals[i+1];
        end
        tbl_count--;
        want.status = ST_DONE;
      end
      rem_tally[want.status]++;
    end
  endfunction

  // Send one request beat; hold it until accepted, then queue its response
  task automatic send_req(input logic op, input logic signed [KEY_W-1:0] k,
                          input logic signed [VAL_W-1:0] v);
    table_rsp_t want;
    if (sender_idle && $urandom_range(99) < 37) begin
      req_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 37);
    end
    req_valid_i <= 1'b1;
    req_type_i  <= op;
    key_i       <= k;
    value_i     <= v;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    apply_request(op, k, v, want);
    pending_rsps.push_back(want);
    req_count++;
  endtask

  // Random request: keys mostly from the table or a small pool so hits are common
  task automatic random_req(input int unsigned insert_pct);
    logic                    op;
    logic signed [KEY_W-1:0] k;
    int unsigned             pick;
    op   = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
    pick = $urandom_range(99);
    if (pick < 45 && tbl_count > 0)
      k = tbl_keys[$urandom_range(tbl_count - 1)];
    else if (pick < 85)
      k = key_pool[$urandom_range(POOL_SIZE - 1)];
    else
      k = $urandom;
    send_req(op, k, $urandom);
  endtask

  // Receiver: stall at random while enabled
  always @(posedge clk_i) begin
    rsp_stall_i <= receiver_idle && ($urandom_range(99) < 37);
  end

  // Check every accepted response beat against the oldest expectation
  always @(posedge clk_i) begin : check_rsp
    table_rsp_t want;
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      if (pending_rsps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: response beat with no request waiting (status %0d, value %0d)",
                   $time, status_o, removed_value_o);
      end else begin
        want = pending_rsps.pop_front();
        if (status_o !== want.status || removed_value_o !== want.removed) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: expected status %0d value %0d, got status %0d value %0d",
                     $time, want.status, want.removed, status_o, removed_value_o);
        end
      end
    end
  end

  // Remove from an empty table
  task automatic test_empty_remove();
    send_req(REQ_REMOVE, '0, KEY_MAX);
  endtask

  // Fill to capacity, extreme keys and values first
  task automatic test_fill_to_full();
    send_req(REQ_INSERT, KEY_MIN, KEY_MAX);
    send_req(REQ_INSERT, KEY_MAX, KEY_MIN);
    send_req(REQ_INSERT, '0, -1);
    send_req(REQ_INSERT, -1, '0);
    send_req(REQ_INSERT, 1, 1);
    while (tbl_count < TBL_DEPTH) send_req(REQ_INSERT, $urandom, $urandom);
  endtask

  // New key into a full table, then a duplicate, which wins over full
  task automatic test_full_cases();
    send_req(REQ_INSERT, 2, 32'sh1234_5678);
    send_req(REQ_INSERT, KEY_MAX, 32'sh0bad_f00d);
  endtask

  // Remove at both ends, remove a missing key, reinsert the low end, then remove key 2
  task automatic test_remove_extremes();
    send_req(REQ_REMOVE, KEY_MIN, $urandom);
    send_req(REQ_REMOVE, KEY_MAX, $urandom);
    send_req(REQ_REMOVE, KEY_MIN, $urandom);
    send_req(REQ_INSERT, KEY_MIN, KEY_MIN);
    send_req(REQ_REMOVE, 2, $urandom);
  endtask

  // Alternate insert-heavy and remove-heavy rounds so the table swings full/empty
  task automatic test_random_mix();
    for (int round = 0; round < 8; round++) begin
      for (int n = 0; n < 63; n++) random_req((round % 2 == 0) ? 75 : 30);
    end
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_burst();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    for (int n = 0; n < 130; n++) random_req(((n / 30) % 2 == 0) ? 70 : 35);
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  initial begin
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = -1;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // Hold reset asserted before starting traffic
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_remove();
    test_fill_to_full();
    test_full_cases();
    test_remove_extremes();
    test_random_mix();
    test_burst();

    // Drain outstanding responses, then allow for pipeline latency
    req_valid_i <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d requests: inserts %0d stored, %0d duplicate, %0d refused as full;",
             req_count, ins_tally[ST_DONE], ins_tally[ST_DUP], ins_tally[ST_FULL]);
    $display("removes %0d found, %0d missing; %0d mismatches",
             rem_tally[ST_DONE], rem_tally[ST_MISSING], mismatch_count);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
